@@ hw/rtl/clcd_pkg.sv @@
// Shared types, register map and codes for the character LCD command sequencer.
package clcd_pkg;

    // APB register map
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_FUNCTION_SET    = 3'd0;
    localparam logic [2:0] REG_DISPLAY_CONTROL = 3'd1;
    localparam logic [2:0] REG_CLEAR           = 3'd2;
    localparam logic [2:0] REG_ENTRY_MODE      = 3'd3;
    localparam logic [2:0] REG_POWER_UP_WAIT   = 3'd4;

    localparam logic [7:0] RST_FUNCTION_SET    = 8'd56;
    localparam logic [7:0] RST_DISPLAY_CONTROL = 8'd12;
    localparam logic [7:0] RST_CLEAR           = 8'h01;
    localparam logic [7:0] RST_ENTRY_MODE      = 8'd6;
    localparam logic [7:0] RST_POWER_UP_WAIT   = 8'd50;

    // Item modes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    // Request status
    localparam logic [1:0] REQ_OK   = 2'd0;
    localparam logic [1:0] REQ_BUSY = 2'd1;
    localparam logic [1:0] REQ_NONE = 2'd2;

    // Pending request kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Position command base
    localparam logic [7:0] POS_BASE = 8'h80;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_value;
        logic [4:0] char_index;
        logic [5:0] text_length;
        logic       row;
        logic [5:0] column;
    } req_item_t;

    typedef struct packed {
        logic       rs_level;
        logic       rw_level;
        logic       en_level;
        logic [7:0] data_lines;
        logic [1:0] request_status;
        logic       busy_res;
        logic       init_done;
    } rsp_item_t;

    typedef struct packed {
        logic [7:0] function_set_cmd;
        logic [7:0] display_control_cmd;
        logic [7:0] clear_cmd;
        logic [7:0] entry_mode_cmd;
        logic [7:0] power_up_wait_ticks;
    } cfg_t;

endpackage

@@ hw/rtl/char_lcd_command_sequencer.sv @@
// Top level of the character LCD command sequencer: item pipeline and APB port.
//
// Usage:
//   req channel (req_valid/req_ready/req_item) carries one item per handshake:
//   a tick, a text character load, a write-string request or a clear request.
//   Every item yields exactly one result item on the rsp channel
//   (rsp_valid/rsp_ready/rsp_item): the RS/RW/EN/data line levels after the
//   item, the request status, the busy flag and the init-done flag.
//   An accepted item enters the input register; its result is then registered.
//   Throughput: one item per cycle while rsp_ready is high; sequencer state is
//   updated in a single pass from the input register to the result register.
//   Stall: when rsp_ready is low the result register holds; the input register
//   still takes one more item, after which req_ready drops until the result
//   is taken.
//   Reset (rst_n low, async): line levels low, start-up sequence restarts at the
//   power-up wait, no request pending, config registers at their defaults.
//   The text buffer is not cleared; slots must be loaded before being sent.
//   APB: five 8-bit registers at byte offsets 0x00..0x10, pready tied high.
//   Write config only while no item is in flight.
module char_lcd_command_sequencer
#(
    parameter int MAX_TEXT = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  clcd_pkg::req_item_t           req_item,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output clcd_pkg::rsp_item_t           rsp_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [clcd_pkg::ADDR_W-1:0]   paddr,
    input  logic [clcd_pkg::DATA_W-1:0]   pwdata,
    output logic [clcd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    clcd_pkg::cfg_t       cfg;
    clcd_pkg::req_item_t  stage_item_reg;
    logic                 stage_valid_reg, stage_valid_next;
    clcd_pkg::rsp_item_t  rsp_item_reg;
    logic                 rsp_valid_reg, rsp_valid_next;
    clcd_pkg::rsp_item_t  core_result;
    logic                 advance;
    logic                 take;

    // input register moves into the result register when that one is free or being taken
    assign advance   = stage_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !stage_valid_reg || advance;
    assign take      = req_valid && req_ready;

    assign stage_valid_next = take || (stage_valid_reg && !advance);
    assign rsp_valid_next   = advance || (rsp_valid_reg && !rsp_ready);

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;
    assign pready    = 1'b1;

    clcd_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    clcd_core #(.MAX_TEXT(MAX_TEXT)) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (stage_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take)
            stage_item_reg <= req_item;
        if (advance)
            rsp_item_reg <= core_result;
    end

    // a refused or newly accepted request always leaves one pending
    a_busy_on_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.request_status == clcd_pkg::REQ_BUSY |-> rsp_item.busy_res)
        else $error("refused request without pending request");

    a_busy_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.request_status == clcd_pkg::REQ_OK |-> rsp_item.busy_res)
        else $error("accepted request not pending");

    // once start-up has finished it never reverts
    a_init_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        advance && core_result.init_done |=> !advance || core_result.init_done)
        else $error("init_done fell");

    // result register is loaded only from a full input stage
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid && !stage_valid_reg |=> !rsp_valid)
        else $error("result appeared without an item");

endmodule

@@ hw/rtl/clcd_cfg_regs.sv @@
// APB configuration registers of the character LCD command sequencer.
module clcd_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [clcd_pkg::ADDR_W-1:0]   paddr,
    input  logic [clcd_pkg::DATA_W-1:0]   pwdata,
    output logic [clcd_pkg::DATA_W-1:0]   prdata,
    output clcd_pkg::cfg_t                cfg
);

    clcd_pkg::cfg_t cfg_reg;
    clcd_pkg::cfg_t cfg_next;
    logic [2:0]     reg_sel;
    logic           wr_en;
    logic [7:0]     rd_byte;

    assign reg_sel = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                clcd_pkg::REG_FUNCTION_SET:    cfg_next.function_set_cmd    = pwdata[7:0];
                clcd_pkg::REG_DISPLAY_CONTROL: cfg_next.display_control_cmd = pwdata[7:0];
                clcd_pkg::REG_CLEAR:           cfg_next.clear_cmd           = pwdata[7:0];
                clcd_pkg::REG_ENTRY_MODE:      cfg_next.entry_mode_cmd      = pwdata[7:0];
                clcd_pkg::REG_POWER_UP_WAIT:   cfg_next.power_up_wait_ticks = pwdata[7:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            clcd_pkg::REG_FUNCTION_SET:    rd_byte = cfg_reg.function_set_cmd;
            clcd_pkg::REG_DISPLAY_CONTROL: rd_byte = cfg_reg.display_control_cmd;
            clcd_pkg::REG_CLEAR:           rd_byte = cfg_reg.clear_cmd;
            clcd_pkg::REG_ENTRY_MODE:      rd_byte = cfg_reg.entry_mode_cmd;
            clcd_pkg::REG_POWER_UP_WAIT:   rd_byte = cfg_reg.power_up_wait_ticks;
            default:                       rd_byte = 8'd0;
        endcase
    end

    assign prdata = {{(clcd_pkg::DATA_W-8){1'b0}}, rd_byte};
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.function_set_cmd    <= clcd_pkg::RST_FUNCTION_SET;
            cfg_reg.display_control_cmd <= clcd_pkg::RST_DISPLAY_CONTROL;
            cfg_reg.clear_cmd           <= clcd_pkg::RST_CLEAR;
            cfg_reg.entry_mode_cmd      <= clcd_pkg::RST_ENTRY_MODE;
            cfg_reg.power_up_wait_ticks <= clcd_pkg::RST_POWER_UP_WAIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hw/rtl/clcd_core.sv @@
// Sequencer state, text buffer and single-pass next-state logic.
module clcd_core
#(
    parameter int MAX_TEXT = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  clcd_pkg::req_item_t   item,
    input  clcd_pkg::cfg_t        cfg,
    output clcd_pkg::rsp_item_t   result
);

    localparam int BUF_DEPTH = (MAX_TEXT < 32) ? MAX_TEXT : 32;
    localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam logic [5:0] BUF_LIMIT = 6'(BUF_DEPTH);
    localparam logic [5:0] LEN_CAP   = 6'((MAX_TEXT > 63) ? 63 : MAX_TEXT);

    // start-up steps
    localparam logic [2:0] INIT_FUNC    = 3'd0;
    localparam logic [2:0] INIT_DISPLAY = 3'd1;
    localparam logic [2:0] INIT_CLEAR   = 3'd2;
    localparam logic [2:0] INIT_ENTRY   = 3'd3;

    // strobe phases
    localparam logic [1:0] PH_DRIVE   = 2'd0;
    localparam logic [1:0] PH_RELEASE = 2'd1;

    logic       initialized_reg,   initialized_next;
    logic [2:0] init_step_reg,     init_step_next;
    logic [7:0] wait_count_reg,    wait_count_next;
    logic [1:0] command_phase_reg, command_phase_next;
    logic [1:0] data_phase_reg,    data_phase_next;
    logic       pending_reg,       pending_next;
    logic [1:0] pending_kind_reg,  pending_kind_next;
    logic       target_row_reg,    target_row_next;
    logic [5:0] target_column_reg, target_column_next;
    logic [5:0] target_length_reg, target_length_next;
    logic       write_step_reg,    write_step_next;
    logic [5:0] char_position_reg, char_position_next;
    logic       rs_reg,            rs_next;
    logic       en_reg,            en_next;
    logic [7:0] data_reg,          data_next;

    logic [7:0] text_buffer [BUF_DEPTH];

    logic       buf_wr;
    logic [7:0] buf_rd;
    logic       stb_sel_data;
    logic [1:0] stb_phase;
    logic       stb_done;
    logic       stb_fire;
    logic       stb_rs;
    logic [7:0] stb_byte;
    logic [7:0] wait_inc;
    logic [7:0] pos_cmd;
    logic [5:0] next_pos;
    logic [1:0] status;

    assign buf_wr = step && (item.mode == clcd_pkg::MODE_LOAD)
                    && ({1'b0, item.char_index} < BUF_LIMIT);
    assign buf_rd = (char_position_reg < BUF_LIMIT)
                    ? text_buffer[char_position_reg[BUF_AW-1:0]] : 8'd0;

    // the data phase counter is used only for characters of a write
    assign stb_sel_data = initialized_reg && (pending_kind_reg == clcd_pkg::KIND_WRITE)
                          && write_step_reg;
    assign stb_phase    = stb_sel_data ? data_phase_reg : command_phase_reg;
    assign stb_done     = (stb_phase != PH_DRIVE) && (stb_phase != PH_RELEASE);

    assign wait_inc = (wait_count_reg == 8'hFF) ? wait_count_reg : wait_count_reg + 8'd1;
    assign pos_cmd  = clcd_pkg::POS_BASE + {1'b0, target_row_reg, 6'd0}
                      + {2'b00, target_column_reg};
    assign next_pos = char_position_reg + 6'd1;

    always_comb
    begin
        initialized_next   = initialized_reg;
        init_step_next     = init_step_reg;
        wait_count_next    = wait_count_reg;
        pending_next       = pending_reg;
        pending_kind_next  = pending_kind_reg;
        target_row_next    = target_row_reg;
        target_column_next = target_column_reg;
        target_length_next = target_length_reg;
        write_step_next    = write_step_reg;
        char_position_next = char_position_reg;
        stb_fire           = 1'b0;
        stb_rs             = 1'b0;
        stb_byte           = 8'd0;
        status             = clcd_pkg::REQ_NONE;

        unique case (item.mode)
            clcd_pkg::MODE_TICK:
            begin
                if (!initialized_reg)
                begin
                    unique case (init_step_reg)
                        INIT_FUNC:
                        begin
                            wait_count_next = wait_inc;
                            if (wait_inc >= cfg.power_up_wait_ticks)
                            begin
                                stb_fire = 1'b1;
                                stb_byte = cfg.function_set_cmd;
                                if (stb_done)
                                    init_step_next = INIT_DISPLAY;
                            end
                        end
                        INIT_DISPLAY:
                        begin
                            stb_fire = 1'b1;
                            stb_byte = cfg.display_control_cmd;
                            if (stb_done)
                                init_step_next = INIT_CLEAR;
                        end
                        INIT_CLEAR:
                        begin
                            stb_fire = 1'b1;
                            stb_byte = cfg.clear_cmd;
                            if (stb_done)
                                init_step_next = INIT_ENTRY;
                        end
                        INIT_ENTRY:
                        begin
                            stb_fire = 1'b1;
                            stb_byte = cfg.entry_mode_cmd;
                            if (stb_done)
                                init_step_next = init_step_reg + 3'd1;
                        end
                        default:
                        begin
                            // final step that marks start-up done, also taken by unused codes
                            initialized_next = 1'b1;
                            init_step_next   = INIT_FUNC;
                        end
                    endcase
                end
                else if (pending_reg)
                begin
                    unique case (pending_kind_reg)
                        clcd_pkg::KIND_WRITE:
                        begin
                            stb_fire = 1'b1;
                            if (!write_step_reg)
                            begin
                                stb_byte = pos_cmd;
                                if (stb_done)
                                begin
                                    if (target_length_reg == 6'd0)
                                    begin
                                        pending_next       = 1'b0;
                                        char_position_next = 6'd0;
                                    end
                                    else
                                    begin
                                        write_step_next = 1'b1;
                                    end
                                end
                            end
                            else
                            begin
                                stb_rs   = 1'b1;
                                stb_byte = buf_rd;
                                if (stb_done)
                                begin
                                    if (next_pos >= target_length_reg)
                                    begin
                                        char_position_next = 6'd0;
                                        write_step_next    = 1'b0;
                                        pending_next       = 1'b0;
                                    end
                                    else
                                    begin
                                        char_position_next = next_pos;
                                    end
                                end
                            end
                        end
                        clcd_pkg::KIND_CLEAR:
                        begin
                            stb_fire = 1'b1;
                            stb_byte = cfg.clear_cmd;
                            if (stb_done)
                                pending_next = 1'b0;
                        end
                        default:
                        begin
                            pending_next = 1'b0;
                        end
                    endcase
                end
            end
            clcd_pkg::MODE_LOAD:
            begin
                status = clcd_pkg::REQ_NONE;
            end
            default:
            begin
                if (pending_reg)
                begin
                    status = clcd_pkg::REQ_BUSY;
                end
                else
                begin
                    status       = clcd_pkg::REQ_OK;
                    pending_next = 1'b1;
                    if (item.mode == clcd_pkg::MODE_WRITE)
                    begin
                        pending_kind_next  = clcd_pkg::KIND_WRITE;
                        target_length_next = (item.text_length > LEN_CAP)
                                             ? LEN_CAP : item.text_length;
                        target_row_next    = item.row;
                        target_column_next = item.column;
                        write_step_next    = 1'b0;
                        char_position_next = 6'd0;
                    end
                    else
                    begin
                        pending_kind_next = clcd_pkg::KIND_CLEAR;
                    end
                end
            end
        endcase
    end

    // strobe: drive lines with EN high, then drop EN, then finish
    always_comb
    begin
        rs_next            = rs_reg;
        en_next            = en_reg;
        data_next          = data_reg;
        command_phase_next = command_phase_reg;
        data_phase_next    = data_phase_reg;
        if (stb_fire)
        begin
            unique case (stb_phase)
                PH_DRIVE:
                begin
                    rs_next   = stb_rs;
                    en_next   = 1'b1;
                    data_next = stb_byte;
                end
                PH_RELEASE:
                begin
                    en_next = 1'b0;
                end
                default:
                begin
                    en_next = en_reg;
                end
            endcase
            if (stb_sel_data)
                data_phase_next = stb_done ? PH_DRIVE : stb_phase + 2'd1;
            else
                command_phase_next = stb_done ? PH_DRIVE : stb_phase + 2'd1;
        end
    end

    always_comb
    begin
        result.rs_level       = rs_next;
        result.rw_level       = 1'b0;
        result.en_level       = en_next;
        result.data_lines     = data_next;
        result.request_status = status;
        result.busy_res       = pending_next;
        result.init_done      = initialized_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initialized_reg   <= 1'b0;
            init_step_reg     <= INIT_FUNC;
            wait_count_reg    <= 8'd0;
            command_phase_reg <= PH_DRIVE;
            data_phase_reg    <= PH_DRIVE;
            pending_reg       <= 1'b0;
            pending_kind_reg  <= clcd_pkg::KIND_NONE;
            target_row_reg    <= 1'b0;
            target_column_reg <= 6'd0;
            target_length_reg <= 6'd0;
            write_step_reg    <= 1'b0;
            char_position_reg <= 6'd0;
            rs_reg            <= 1'b0;
            en_reg            <= 1'b0;
            data_reg          <= 8'd0;
        end
        else if (step)
        begin
            initialized_reg   <= initialized_next;
            init_step_reg     <= init_step_next;
            wait_count_reg    <= wait_count_next;
            command_phase_reg <= command_phase_next;
            data_phase_reg    <= data_phase_next;
            pending_reg       <= pending_next;
            pending_kind_reg  <= pending_kind_next;
            target_row_reg    <= target_row_next;
            target_column_reg <= target_column_next;
            target_length_reg <= target_length_next;
            write_step_reg    <= write_step_next;
            char_position_reg <= char_position_next;
            rs_reg            <= rs_next;
            en_reg            <= en_next;
            data_reg          <= data_next;
        end
    end

    // text buffer: no reset; slots must be loaded before use, the block does not enforce it
    always_ff @(posedge clk)
    begin
        if (buf_wr)
            text_buffer[item.char_index[BUF_AW-1:0]] <= item.char_value;
    end

endmodule
